// ===== rtl/rhi_pkg.sv =====
package rhi_pkg;

    localparam int unsigned ChanW  = 5;
    localparam int unsigned ColorW = 3 * ChanW;
    localparam int unsigned QuotW  = 9;
    localparam int unsigned HueW   = 11;
    localparam int unsigned WeightW = 9;
    localparam int unsigned ScaleW = 13;
    localparam int unsigned PixW   = 10;

    // Hue is kept in 1/256 sextants; a full turn is six sextants.
    localparam logic [HueW-1:0] HUE_FULL   = 11'd1536;
    localparam logic [HueW-1:0] HUE_HALF   = 11'd768;
    localparam logic [HueW-1:0] BASE_GREEN = 11'd512;
    localparam logic [HueW-1:0] BASE_BLUE  = 11'd1024;
    localparam logic [ScaleW-1:0] CH_SCALE = 13'd7936;

    // ceil(2^20 / d): a multiply by this and a shift divides exactly for
    // the narrow dividends used here. Entry zero is never a real divisor.
    localparam int unsigned RecipW = 21;
    localparam logic [RecipW-1:0] RECIP_TABLE [32] = '{
        21'd0,      21'd1048576, 21'd524288, 21'd349526,
        21'd262144, 21'd209716,  21'd174763, 21'd149797,
        21'd131072, 21'd116509,  21'd104858, 21'd95326,
        21'd87382,  21'd80660,   21'd74899,  21'd69906,
        21'd65536,  21'd61681,   21'd58255,  21'd55189,
        21'd52429,  21'd49933,   21'd47663,  21'd45591,
        21'd43691,  21'd41944,   21'd40330,  21'd38837,
        21'd37450,  21'd36158,   21'd34953,  21'd33826
    };

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // Hue quotient and saturation handed from the split to the hue stages.
    typedef struct packed {
        logic [ChanW-1:0] bright;
        logic [ChanW-1:0] sat;
        logic [QuotW-1:0] quot;
        logic             neg;
        max_sel_t         sel;
    } ratio_t;

    // Per-channel weights handed from the hue stages to the rebuild.
    typedef struct packed {
        logic [ChanW-1:0]            bright;
        logic [ChanW-1:0]            sat;
        logic [2:0][WeightW-1:0]     weight;
    } weight_t;

endpackage

// ===== rtl/rhi_split.sv =====
module rhi_split
    import rhi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ColorW-1:0] in_color,
    output logic              out_valid,
    output ratio_t            out_ratio
);

    logic [ChanW-1:0] r, g, b;
    logic [ChanW-1:0] bright_next, low_next, num_a, num_b;
    max_sel_t         sel_next;

    logic             v1_reg;
    logic [ChanW-1:0] bright1_reg, delta1_reg, mag1_reg;
    logic             neg1_reg;
    max_sel_t         sel1_reg;

    logic [25:0]      prod_q;
    logic [9:0]       sat_num;
    logic [30:0]      prod_s;
    ratio_t           ratio_next;

    logic             v2_reg;
    ratio_t           ratio_reg;

    // Stage 1: maximum, minimum and the signed hue numerator.
    always_comb
    begin
        r = in_color[ChanW-1:0];
        g = in_color[2*ChanW-1:ChanW];
        b = in_color[3*ChanW-1:2*ChanW];
        if (r >= g && r >= b)
        begin
            sel_next    = MAX_RED;
            bright_next = r;
            num_a       = g;
            num_b       = b;
        end
        else if (g >= b)
        begin
            sel_next    = MAX_GREEN;
            bright_next = g;
            num_a       = b;
            num_b       = r;
        end
        else
        begin
            sel_next    = MAX_BLUE;
            bright_next = b;
            num_a       = r;
            num_b       = g;
        end
        low_next = r;
        if (g < low_next)
        begin
            low_next = g;
        end
        if (b < low_next)
        begin
            low_next = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bright1_reg <= bright_next;
            delta1_reg  <= bright_next - low_next;
            neg1_reg    <= (num_a < num_b);
            mag1_reg    <= (num_a < num_b) ? (num_b - num_a) : (num_a - num_b);
            sel1_reg    <= sel_next;
        end
    end

    // Stage 2: both divisions by reciprocal multiply.
    always_comb
    begin
        prod_q  = 26'(mag1_reg) * 26'(RECIP_TABLE[delta1_reg]);
        sat_num = 10'(delta1_reg) * 10'd31;
        prod_s  = 31'(sat_num) * 31'(RECIP_TABLE[bright1_reg]);
        ratio_next.bright = bright1_reg;
        ratio_next.sat    = prod_s[24:20];
        ratio_next.quot   = prod_q[20:12];
        ratio_next.neg    = neg1_reg;
        ratio_next.sel    = sel1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ratio_reg <= ratio_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_ratio = ratio_reg;

endmodule

// ===== rtl/rhi_hue.sv =====
module rhi_hue
    import rhi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  ratio_t  in_ratio,
    output logic    out_valid,
    output weight_t out_weight
);

    // Channel offsets for red, green and blue.
    localparam logic [HueW-1:0] OFFSETS [3] = '{11'd1280, 11'd768, 11'd256};

    function automatic logic [WeightW-1:0] tri_weight(input logic [HueW-1:0] k);
        logic [HueW-1:0] span;
        begin
            if (k <= 11'd512)
            begin
                span = k;
            end
            else if (k < BASE_BLUE)
            begin
                span = BASE_BLUE - k;
            end
            else
            begin
                span = '0;
            end
            tri_weight = (span > 11'd256) ? 9'd256 : span[WeightW-1:0];
        end
    endfunction

    logic signed [11:0] base_s, step_s, hue_s;
    logic [HueW-1:0]    hue_wrap;
    logic [11:0]        hue_adv;
    logic [HueW-1:0]    hue_next;

    logic               v3_reg;
    logic [HueW-1:0]    hue3_reg;
    logic [ChanW-1:0]   bright3_reg, sat3_reg;

    logic [11:0]        ksum;
    logic [HueW-1:0]    kval;
    weight_t            weight_next;

    logic               v4_reg;
    weight_t            weight_reg;

    // Stage 3: hue in sextant units, advanced by half a turn.
    always_comb
    begin
        case (in_ratio.sel)
            MAX_RED:   base_s = 12'sd0;
            MAX_GREEN: base_s = signed'(12'(BASE_GREEN));
            MAX_BLUE:  base_s = signed'(12'(BASE_BLUE));
            default:   base_s = 12'sd0;
        endcase
        step_s = signed'(12'(in_ratio.quot));
        if (in_ratio.neg)
        begin
            step_s = -step_s;
        end
        hue_s = base_s + step_s;
        if (hue_s < 12'sd0)
        begin
            hue_wrap = 11'(unsigned'(hue_s) + 12'(HUE_FULL));
        end
        else
        begin
            hue_wrap = 11'(unsigned'(hue_s));
        end
        hue_adv = 12'(hue_wrap) + 12'(HUE_HALF);
        if (hue_adv >= 12'(HUE_FULL))
        begin
            hue_next = 11'(hue_adv - 12'(HUE_FULL));
        end
        else
        begin
            hue_next = hue_adv[HueW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue3_reg    <= hue_next;
            bright3_reg <= in_ratio.bright;
            sat3_reg    <= in_ratio.sat;
        end
    end

    // Stage 4: triangular weight of each channel around the hue circle.
    always_comb
    begin
        weight_next.bright = bright3_reg;
        weight_next.sat    = sat3_reg;
        weight_next.weight = '0;
        ksum = '0;
        kval = '0;
        for (int i = 0; i < 3; i++)
        begin
            ksum = 12'(hue3_reg) + 12'(OFFSETS[i]);
            if (ksum >= 12'(HUE_FULL))
            begin
                kval = 11'(ksum - 12'(HUE_FULL));
            end
            else
            begin
                kval = ksum[HueW-1:0];
            end
            weight_next.weight[i] = tri_weight(kval);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_weight = weight_reg;

endmodule

// ===== rtl/rhi_build.sv =====
module rhi_build
    import rhi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  weight_t           in_weight,
    output logic              out_valid,
    output logic [ColorW-1:0] out_color
);

    logic [2:0][ScaleW-1:0] scale_next;
    logic [13:0]            sat_prod;

    logic                   v5_reg;
    logic [2:0][ScaleW-1:0] scale5_reg;
    logic [ChanW-1:0]       bright5_reg;

    logic [2:0][PixW-1:0]   pix_next;
    logic [17:0]            level;

    logic                   v6_reg;
    logic [2:0][PixW-1:0]   pix6_reg;

    logic [ColorW-1:0]      color_next;
    logic [25:0]            chan_prod;

    logic                   v7_reg;
    logic [ColorW-1:0]      color_reg;

    // Stage 5: 7936 - sat * weight per channel.
    always_comb
    begin
        sat_prod   = '0;
        scale_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            sat_prod      = 14'(in_weight.sat) * 14'(in_weight.weight[i]);
            scale_next[i] = 13'(14'(CH_SCALE) - sat_prod);
        end
    end

    // Stage 6: scale by brightness, then drop the power-of-two part of 7936.
    always_comb
    begin
        level    = '0;
        pix_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            level       = 18'(bright5_reg) * 18'(scale5_reg[i]);
            pix_next[i] = level[17:8];
        end
    end

    // Stage 7: the remaining divide by 31 as a reciprocal multiply.
    always_comb
    begin
        chan_prod  = '0;
        color_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            chan_prod = 26'(pix6_reg[i]) * 26'(RECIP_TABLE[31]);
            color_next[i*ChanW +: ChanW] = chan_prod[24:20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale5_reg  <= scale_next;
            bright5_reg <= in_weight.bright;
            pix6_reg    <= pix_next;
            color_reg   <= color_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_color = color_reg;

endmodule

// ===== rtl/rhi_skid.sv =====
module rhi_skid
    import rhi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ColorW-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ColorW-1:0] out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [ColorW-1:0] out_data_reg, skid_data_reg;
    logic              take_in, drain;

    always_comb
    begin
        take_in         = in_valid && !skid_valid_reg;
        drain           = out_ready || !out_valid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (drain)
        begin
            out_valid_next  = skid_valid_reg || take_in;
            skid_valid_next = 1'b0;
        end
        else if (take_in)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (take_in)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/rgb555_hue_invert_top.sv =====
// RGB555 hue inverter: each color transfer on the slave stream comes back
// on the master stream with its hue turned half way around the color
// circle, keeping brightness (the largest channel) and saturation.
// Both streams carry one RGB555 color per transfer in tdata bits 14:0
// (red 4:0, green 9:5, blue 14:10); bit 15 is unused on input and zero
// on output. There is no configuration and no state between colors.
// Path: a color accepted on the slave stream passes through seven pipeline
// stages and then the output register before it shows on m_tvalid/m_tdata.
// Throughput: one color per cycle, sustained while m_tready stays high,
// through the seven-stage pipeline; stage 2 chains two multiplies.
// Stalls: when the receiver drops m_tready the result holds on the output
// register and one more result lands in the skid register; after that
// s_tready falls and the whole pipeline freezes in place, so nothing is
// lost or repeated. s_tready depends only on registered state.
// Reset: rst_n clears every valid bit at once; s_tready stays high, so the
// block accepts a new transfer as soon as reset is released.
module rgb555_hue_invert_top
    import rhi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // color_in[14:0], pad[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // color_out[14:0], zero[15]
);

    logic              en;
    logic              split_valid, hue_valid, build_valid;
    ratio_t            split_ratio;
    weight_t           hue_weight;
    logic [ColorW-1:0] build_color, out_color;

    // The pipeline moves whenever the skid stage can take its last item.
    assign s_tready = en;

    // Stages 1 and 2: channel extremes, hue quotient and saturation.
    rhi_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_color  (s_tdata[ColorW-1:0]),
        .out_valid (split_valid),
        .out_ratio (split_ratio)
    );

    // Stages 3 and 4: rotated hue and per-channel weights.
    rhi_hue u_hue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (split_valid),
        .in_ratio   (split_ratio),
        .out_valid  (hue_valid),
        .out_weight (hue_weight)
    );

    // Stages 5 to 7: rebuild the three channels.
    rhi_build u_build
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hue_valid),
        .in_weight (hue_weight),
        .out_valid (build_valid),
        .out_color (build_color)
    );

    // Output register plus skid slot; its ready is the pipeline enable.
    rhi_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (build_valid),
        .in_ready  (en),
        .in_data   (build_color),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_color)
    );

    assign m_tdata = {1'b0, out_color};

endmodule
